FILE: hdl/itt_pkg.sv
package itt_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCAN_W  = $clog2(SLOTS + 1);
  localparam int COUNT_W = $clog2(SLOTS + 1);

  localparam int TIME_W  = 32;
  localparam int TYPE_W  = 8;
  localparam int DELAY_W = 16;
  localparam int FUNC_W  = 2;
  localparam int RCNT_W  = 5;

  localparam int TYPE_LSB  = FUNC_W;
  localparam int DELAY_LSB = FUNC_W + TYPE_W;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_CHECK  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_UPD,
    ST_CANCEL_SCAN,
    ST_CHECK_RD,
    ST_RESCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [TYPE_W-1:0] ttype;
    logic [TIME_W-1:0] deadline;
  } itt_entry_t;

  typedef struct packed {
    logic               valid;
    func_e              func;
    logic [TYPE_W-1:0]  ttype;
    logic [DELAY_W-1:0] delay;
  } itt_req_t;

  // packed from the lowest bit up: fired, fired_type, removed_count, table_full
  typedef struct packed {
    logic              table_full;
    logic [RCNT_W-1:0] removed_count;
    logic [TYPE_W-1:0] fired_type;
    logic              fired;
  } itt_result_t;

  localparam int RES_W = $bits(itt_result_t);

  function automatic logic [RCNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
    logic [RCNT_W-1:0] r;
    if (32'(c) > 32'd31) begin
      r = 5'd31;
    end else begin
      r = RCNT_W'(c);
    end
    return r;
  endfunction

endpackage

FILE: hdl/itt_mem.sv
module itt_mem
  import itt_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_addr_i,
  input  itt_entry_t        wr_data_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output itt_entry_t        rd_data_o
);

  itt_entry_t mem [SLOTS];
  itt_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/itt_seq.sv
module itt_seq
  import itt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itt_req_t          req_i,
  output logic              ready_o,
  output logic              res_valid_o,
  output itt_result_t       res_o,
  input  logic              res_ready_i,
  output logic              mem_we_o,
  output logic [SLOT_W-1:0] mem_waddr_o,
  output itt_entry_t        mem_wdata_o,
  output logic [SLOT_W-1:0] mem_raddr_o,
  input  itt_entry_t        mem_rdata_i
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  state_e             state_q, state_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TIME_W-1:0]  ed_q, ed_d;
  logic [TIME_W-1:0]  new_dl_q, new_dl_d;
  logic [SLOT_W-1:0]  es_q, es_d;
  logic [SLOT_W-1:0]  new_slot_q, new_slot_d;
  logic [SLOT_W-1:0]  proc_idx_q, proc_idx_d;
  logic               ev_q, ev_d;
  logic               proc_vld_q, proc_vld_d;
  logic [SCAN_W-1:0]  scan_idx_q, scan_idx_d;
  logic [TYPE_W-1:0]  ctype_q, ctype_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  itt_result_t        res_q, res_d;

  // shared adder and comparator
  logic [TIME_W-1:0]  add_b, sum;
  logic [TIME_W-1:0]  cmp_a, cmp_b;
  logic               cmp_lt, cmp_eq;

  logic               free_found;
  logic [SLOT_W-1:0]  free_idx;
  logic               match;
  logic [COUNT_W-1:0] cnt_final;

  assign add_b  = (req_i.func == FUNC_TICK) ? TIME_W'(1) : TIME_W'(req_i.delay);
  assign sum    = now_q + add_b;
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_eq = cmp_a == cmp_b;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(k);
      end
    end
  end

  assign match     = valid_q[proc_idx_q] && (mem_rdata_i.ttype == ctype_q);
  assign cnt_final = match ? cnt_q + COUNT_W'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      now_q      <= '0;
      ed_q       <= '0;
      es_q       <= '0;
      ev_q       <= 1'b0;
      proc_vld_q <= 1'b0;
      scan_idx_q <= '0;
      cnt_q      <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      now_q      <= now_d;
      ed_q       <= ed_d;
      es_q       <= es_d;
      ev_q       <= ev_d;
      proc_vld_q <= proc_vld_d;
      scan_idx_q <= scan_idx_d;
      cnt_q      <= cnt_d;
      res_q      <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_dl_q   <= new_dl_d;
    new_slot_q <= new_slot_d;
    proc_idx_q <= proc_idx_d;
    ctype_q    <= ctype_d;
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    now_d       = now_q;
    ed_d        = ed_q;
    es_d        = es_q;
    ev_d        = ev_q;
    new_dl_d    = new_dl_q;
    new_slot_d  = new_slot_q;
    proc_idx_d  = proc_idx_q;
    proc_vld_d  = 1'b0;
    scan_idx_d  = scan_idx_q;
    ctype_d     = ctype_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = free_idx;
    mem_wdata_o = '{ttype: req_i.ttype, deadline: sum};
    mem_raddr_o = es_q;
    cmp_a       = now_q;
    cmp_b       = ed_q;

    // slot issue for both scan states, one read per cycle
    if (state_q == ST_CANCEL_SCAN || state_q == ST_RESCAN) begin
      mem_raddr_o = scan_idx_q[SLOT_W-1:0];
      if (scan_idx_q < SCAN_W'(SLOTS)) begin
        scan_idx_d = scan_idx_q + SCAN_W'(1);
        proc_vld_d = 1'b1;
        proc_idx_d = scan_idx_q[SLOT_W-1:0];
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (req_i.valid) begin
          res_d = '0;
          unique case (req_i.func)
            FUNC_TICK: begin
              now_d   = sum;
              state_d = ST_DONE;
            end
            FUNC_ADD: begin
              if (free_found) begin
                mem_we_o          = 1'b1;
                valid_d[free_idx] = 1'b1;
                new_dl_d          = sum;
                new_slot_d        = free_idx;
                state_d           = ST_ADD_UPD;
              end else begin
                res_d.table_full = 1'b1;
                state_d          = ST_DONE;
              end
            end
            FUNC_CANCEL: begin
              ctype_d    = req_i.ttype;
              cnt_d      = '0;
              scan_idx_d = '0;
              state_d    = ST_CANCEL_SCAN;
            end
            FUNC_CHECK: begin
              // due when deadline <= now; read issued at earliest slot
              if (ev_q && !cmp_lt) begin
                state_d = ST_CHECK_RD;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_ADD_UPD: begin
        cmp_a = new_dl_q;
        cmp_b = ed_q;
        if (!ev_q || cmp_lt || (cmp_eq && (new_slot_q < es_q))) begin
          ev_d = 1'b1;
          es_d = new_slot_q;
          ed_d = new_dl_q;
        end
        state_d = ST_DONE;
      end

      ST_CANCEL_SCAN: begin
        if (proc_vld_q) begin
          if (match) begin
            valid_d[proc_idx_q] = 1'b0;
          end
          cnt_d = cnt_final;
          if (proc_idx_q == LAST_SLOT) begin
            res_d.removed_count = sat_count(cnt_final);
            proc_vld_d          = 1'b0;
            if (cnt_final != '0) begin
              scan_idx_d = '0;
              ev_d       = 1'b0;
              state_d    = ST_RESCAN;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_CHECK_RD: begin
        res_d.fired      = 1'b1;
        res_d.fired_type = mem_rdata_i.ttype;
        valid_d[es_q]    = 1'b0;
        scan_idx_d       = '0;
        ev_d             = 1'b0;
        state_d          = ST_RESCAN;
      end

      ST_RESCAN: begin
        cmp_a = mem_rdata_i.deadline;
        cmp_b = ed_q;
        if (proc_vld_q) begin
          if (valid_q[proc_idx_q] && (!ev_q || cmp_lt)) begin
            ev_d = 1'b1;
            es_d = proc_idx_q;
            ed_d = mem_rdata_i.deadline;
          end
          if (proc_idx_q == LAST_SLOT) begin
            proc_vld_d = 1'b0;
            state_d    = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = res_q;

endmodule

FILE: hdl/interval_timer_table.sv
// Interval timer table: SLOTS one-shot timers against a seconds counter that
// advances on tick, with the earliest pending deadline tracked in registers.
// Input channel (s_axis): one beat per operation. func selects tick (advance
// time one second), add (arm lowest free slot at now + delay_secs), cancel
// (free every timer of timer_type) or check (fire and free the earliest timer
// if its deadline <= now). Output channel (m_axis): exactly one beat per
// operation with fired, fired_type, removed_count and table_full.
// Steps from input accept to the load of the output register:
//   tick, check with nothing due, add to a full table: result directly
//   add: slot write, then earliest-deadline update
//   check that fires: slot read, then earliest rescan over all SLOTS
//   cancel: scan of all SLOTS, plus an earliest rescan when anything was removed
// The rescan walks the slot memory one entry per cycle through its single
// registered read port and feeds one shared comparator. One operation is
// in flight at a time: s_axis_tready_o is high only while the sequencer
// is idle.
// A result beat sits in the output register; the next operation is accepted
// while it waits. If the receiver stalls, the following result is held in
// the sequencer until the register frees up. Reset empties the table, zeroes
// the seconds counter and drops any pending output beat.
module interval_timer_table
  import itt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [1:0] func, [9:2] timer_type, [25:10] delay_secs, [31:26] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [0] fired, [8:1] fired_type, [13:9] removed_count, [14] table_full, [15] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  itt_req_t          req;
  itt_result_t       res;
  logic              res_valid, res_ready;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  itt_entry_t        mem_wdata, mem_rdata;

  logic              m_valid_q, m_valid_d;
  itt_result_t       m_data_q, m_data_d;

  // unpack the input beat
  assign req.valid = s_axis_tvalid_i;
  assign req.func  = func_e'(s_axis_tdata_i[FUNC_W-1:0]);
  assign req.ttype = s_axis_tdata_i[TYPE_LSB +: TYPE_W];
  assign req.delay = s_axis_tdata_i[DELAY_LSB +: DELAY_W];

  itt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .ready_o     (s_axis_tready_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // deadline and type per slot; valid bits live in the sequencer
  itt_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  // output register
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_data_d  = res;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(m_data_q);

endmodule

FILE: hdl/itt_checker.sv
module itt_checker
  import itt_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat dropped or changed under stall");

  // one operation in flight: no accept in the cycle after an accept
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while previous operation busy");

  // a fired timer and a rejected add never share a result
  a_fire_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[14]))
    else $error("fired and table_full both set");

  // no fire means no fired type
  a_type_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[8:1] == '0)
    else $error("fired_type set without fired");

endmodule

bind interval_timer_table itt_checker u_itt_checker (.*);
